// ===== hw/rtl/dmds_pkg.sv =====
// Package for the dual motor direction sequencer: codes, state and item types.
// Used by dmds_step and the top level; depends on nothing.
`default_nettype none

package dmds_pkg;

  localparam int unsigned MS_W   = 22;
  localparam int unsigned DEAD_W = 16;

  localparam logic [MS_W-1:0] MAX_RUN_MS          = 22'd3600000;
  localparam logic [MS_W-1:0] AUTO_INTERVAL_RESET = 22'd5000;

  // func codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_POLL = 2'd2;

  // command kinds
  localparam logic [1:0] CMD_RESUME = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  // command channel select
  localparam logic [1:0] CH_A    = 2'd0;
  localparam logic [1:0] CH_B    = 2'd1;
  localparam logic [1:0] CH_BOTH = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_AUTO_INTERVAL = 3'd0;
  localparam logic [2:0] REG_REVERSE_DEAD  = 3'd1;
  localparam logic [2:0] REG_START_FWD     = 3'd2;
  localparam logic [2:0] REG_CHAN_B_EN     = 3'd3;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [MS_W-1:0]   phase_len_ms;
    logic [DEAD_W-1:0] reverse_dead_ms;
    logic              auto_start_forward;
    logic              second_channel_enable;
  } cfg_t;

  typedef struct packed {
    logic              auto_on;
    logic              auto_dir_forward;
    logic [MS_W-1:0]   auto_left_ms;
    logic              auto_braking_flag;
    logic [DEAD_W-1:0] dead_left_ms;
    logic              next_dir_forward;
    dir_t              chan_a_dir;
    dir_t              chan_b_dir;
    logic [MS_W-1:0]   chan_a_left_ms;
    logic [MS_W-1:0]   chan_b_left_ms;
    logic [3:0]        pin_levels;   // [0] A fwd, [1] A rev, [2] B fwd, [3] B rev
  } state_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [1:0]      cmd_kind;
    logic [1:0]      cmd_channel;
    logic            cmd_reverse;
    logic [MS_W-1:0] run_ms;
    logic            button_up;
    logic            button_down;
    logic            limit_up;
    logic            limit_down;
  } item_t;

  function automatic logic [1:0] pins_of(dir_t d);
    logic [1:0] p;
    p = 2'b00;
    if (d == DIR_FWD) begin
      p = 2'b01;
    end else if (d == DIR_REV) begin
      p = 2'b10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dmds_step.sv =====
// Next-state logic for one item: tick, command or poll applied to the current state.
// Purely combinational; depends on dmds_pkg.
`default_nettype none

module dmds_step (
  input  dmds_pkg::state_t cur,
  input  dmds_pkg::cfg_t   cfg,
  input  dmds_pkg::item_t  item,
  output dmds_pkg::state_t nxt
);

  always_comb begin
    dmds_pkg::state_t    s;
    logic                use_a;
    logic                use_b;
    logic                any_btn;
    logic [dmds_pkg::MS_W-1:0] ms;
    dmds_pkg::dir_t      run_dir;
    dmds_pkg::dir_t      set_dir;

    s       = cur;
    use_a   = (item.cmd_channel == dmds_pkg::CH_A) ||
              (item.cmd_channel == dmds_pkg::CH_BOTH);
    use_b   = (item.cmd_channel == dmds_pkg::CH_B) ||
              (item.cmd_channel == dmds_pkg::CH_BOTH);
    any_btn = item.button_up || item.button_down;
    ms      = (item.run_ms > dmds_pkg::MAX_RUN_MS) ? dmds_pkg::MAX_RUN_MS : item.run_ms;
    run_dir = item.cmd_reverse ? dmds_pkg::DIR_REV : dmds_pkg::DIR_FWD;
    set_dir = dmds_pkg::DIR_STOP;

    unique case (item.func)
      dmds_pkg::FUNC_TICK: begin
        if (s.auto_on) begin
          if (s.auto_braking_flag) begin
            if (s.dead_left_ms != '0) begin
              s.dead_left_ms = s.dead_left_ms - 16'd1;
              if (s.dead_left_ms == '0) begin
                s.auto_braking_flag = 1'b0;
                s.auto_dir_forward  = s.next_dir_forward;
                s.auto_left_ms      = cfg.phase_len_ms;
              end
            end
          end else if (s.auto_left_ms != '0) begin
            s.auto_left_ms = s.auto_left_ms - 22'd1;
            if (s.auto_left_ms == '0) begin
              s.next_dir_forward = !s.auto_dir_forward;
              if (cfg.reverse_dead_ms != '0) begin
                s.auto_braking_flag = 1'b1;
                s.dead_left_ms      = cfg.reverse_dead_ms;
              end else begin
                s.auto_dir_forward = s.next_dir_forward;
                s.auto_left_ms     = cfg.phase_len_ms;
              end
            end
          end
        end
        if (s.chan_a_left_ms != '0) begin
          s.chan_a_left_ms = s.chan_a_left_ms - 22'd1;
          if (s.chan_a_left_ms == '0) s.chan_a_dir = dmds_pkg::DIR_STOP;
        end
        if (s.chan_b_left_ms != '0) begin
          s.chan_b_left_ms = s.chan_b_left_ms - 22'd1;
          if (s.chan_b_left_ms == '0) s.chan_b_dir = dmds_pkg::DIR_STOP;
        end
      end

      dmds_pkg::FUNC_CMD: begin
        if (item.cmd_kind == dmds_pkg::CMD_RESUME) begin
          s.auto_on           = 1'b1;
          s.auto_dir_forward  = cfg.auto_start_forward;
          s.auto_left_ms      = cfg.phase_len_ms;
          s.auto_braking_flag = 1'b0;
          s.dead_left_ms      = '0;
        end else if (item.cmd_kind == dmds_pkg::CMD_STOP &&
                     item.cmd_channel <= dmds_pkg::CH_BOTH) begin
          s.auto_on = 1'b0;
          if (use_a) begin
            s.chan_a_dir       = dmds_pkg::DIR_STOP;
            s.chan_a_left_ms   = '0;
            s.pin_levels[1:0]  = 2'b00;
          end
          if (use_b) begin
            s.chan_b_dir       = dmds_pkg::DIR_STOP;
            s.chan_b_left_ms   = '0;
            s.pin_levels[3:2]  = 2'b00;
          end
        end else if (item.cmd_kind == dmds_pkg::CMD_RUN &&
                     item.cmd_channel <= dmds_pkg::CH_BOTH) begin
          s.auto_on = 1'b0;
          if (use_a) begin
            s.chan_a_dir     = run_dir;
            s.chan_a_left_ms = ms;
          end
          if (use_b) begin
            s.chan_b_dir     = run_dir;
            s.chan_b_left_ms = ms;
          end
        end
      end

      dmds_pkg::FUNC_POLL: begin
        if (any_btn) s.auto_on = 1'b0;
        // buttons override auto; both buttons together stop
        if (s.auto_on) begin
          set_dir = s.auto_braking_flag ? dmds_pkg::DIR_STOP
                  : (s.auto_dir_forward ? dmds_pkg::DIR_FWD : dmds_pkg::DIR_REV);
        end else if (item.button_up && !item.button_down) begin
          set_dir = dmds_pkg::DIR_FWD;
        end else if (item.button_down && !item.button_up) begin
          set_dir = dmds_pkg::DIR_REV;
        end
        if (s.auto_on || any_btn) begin
          s.chan_a_dir     = set_dir;
          s.chan_b_dir     = set_dir;
          s.chan_a_left_ms = '0;
          s.chan_b_left_ms = '0;
        end
        if (s.chan_a_dir == dmds_pkg::DIR_STOP ||
            (s.chan_a_dir == dmds_pkg::DIR_FWD && item.limit_up) ||
            (s.chan_a_dir == dmds_pkg::DIR_REV && item.limit_down)) begin
          s.chan_a_dir      = dmds_pkg::DIR_STOP;
          s.chan_a_left_ms  = '0;
          s.pin_levels[1:0] = 2'b00;
        end else begin
          s.pin_levels[1:0] = dmds_pkg::pins_of(s.chan_a_dir);
        end
        if (s.chan_b_dir == dmds_pkg::DIR_STOP || !cfg.second_channel_enable ||
            (s.chan_b_dir == dmds_pkg::DIR_FWD && item.limit_up) ||
            (s.chan_b_dir == dmds_pkg::DIR_REV && item.limit_down)) begin
          s.chan_b_dir      = dmds_pkg::DIR_STOP;
          s.chan_b_left_ms  = '0;
          s.pin_levels[3:2] = 2'b00;
        end else begin
          s.pin_levels[3:2] = dmds_pkg::pins_of(s.chan_b_dir);
        end
      end

      default: begin
        // unused func code: state unchanged
      end
    endcase

    nxt = s;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_motor_direction_sequencer_top.sv =====
// Top level of the dual motor direction sequencer: state, config registers, result stage.
// Depends on dmds_pkg and dmds_step.
//
// Usage:
//   Input channel (in_*): one item per handshake; in_func selects a 1 ms tick, a
//   decoded command or a poll of buttons and limit switches.
//   Result channel (out_*): exactly one item per input item, carrying the four
//   H-bridge pin levels and the auto flag after that item.
//   Config channel (cfg_*): always ready; write only while no item is in flight.
//   The auto interval is clamped to 1..3600000 on write; indexes above 3 are dropped.
//   Latency: the result is valid the cycle after the input is accepted.
//   Throughput: one item per cycle while results are taken; the state update is a single
//   pass of compares and 22- and 16-bit decrements between state and result registers.
//   Receiver stall: the result register holds; in_ready stays high only while the
//   result is being taken in the same cycle, so nothing is lost or repeated.
//   Reset (rst_n low, synchronous): auto mode on, start direction forward, 5000 ms
//   interval, both channels stopped with pins braked, no result pending.
`default_nettype none

module dual_motor_direction_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_cmd_kind,
  input  wire logic [1:0]  in_cmd_channel,
  input  wire logic        in_cmd_reverse,
  input  wire logic [21:0] in_run_ms,
  input  wire logic        in_button_up,
  input  wire logic        in_button_down,
  input  wire logic        in_limit_up,
  input  wire logic        in_limit_down,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_a_forward_pin,
  output logic             out_a_reverse_pin,
  output logic             out_b_forward_pin,
  output logic             out_b_reverse_pin,
  output logic             out_auto_active,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_data
);

  dmds_pkg::state_t state_r;
  dmds_pkg::state_t state_nxt;
  dmds_pkg::cfg_t   cfg_r;
  dmds_pkg::item_t  item;
  logic             out_valid_r;
  logic [3:0]       pins_r;
  logic             auto_r;
  logic             in_acc;
  logic [21:0]      interval_clamped;

  assign item.func        = in_func;
  assign item.cmd_kind    = in_cmd_kind;
  assign item.cmd_channel = in_cmd_channel;
  assign item.cmd_reverse = in_cmd_reverse;
  assign item.run_ms      = in_run_ms;
  assign item.button_up   = in_button_up;
  assign item.button_down = in_button_down;
  assign item.limit_up    = in_limit_up;
  assign item.limit_down  = in_limit_down;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign interval_clamped = (cfg_data == '0) ? 22'd1
                          : ((cfg_data > dmds_pkg::MAX_RUN_MS) ? dmds_pkg::MAX_RUN_MS : cfg_data);

  dmds_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (item),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_len_ms          <= dmds_pkg::AUTO_INTERVAL_RESET;
      cfg_r.reverse_dead_ms       <= '0;
      cfg_r.auto_start_forward    <= 1'b1;
      cfg_r.second_channel_enable <= 1'b1;
      state_r.auto_on             <= 1'b1;
      state_r.auto_dir_forward    <= 1'b1;
      state_r.auto_left_ms        <= dmds_pkg::AUTO_INTERVAL_RESET;
      state_r.auto_braking_flag   <= 1'b0;
      state_r.dead_left_ms        <= '0;
      state_r.next_dir_forward    <= 1'b1;
      state_r.chan_a_dir          <= dmds_pkg::DIR_STOP;
      state_r.chan_b_dir          <= dmds_pkg::DIR_STOP;
      state_r.chan_a_left_ms      <= '0;
      state_r.chan_b_left_ms      <= '0;
      state_r.pin_levels          <= '0;
      out_valid_r                 <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dmds_pkg::REG_AUTO_INTERVAL: cfg_r.phase_len_ms          <= interval_clamped;
          dmds_pkg::REG_REVERSE_DEAD:  cfg_r.reverse_dead_ms       <= cfg_data[15:0];
          dmds_pkg::REG_START_FWD:     cfg_r.auto_start_forward    <= cfg_data[0];
          dmds_pkg::REG_CHAN_B_EN:     cfg_r.second_channel_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pins_r <= state_nxt.pin_levels;
      auto_r <= state_nxt.auto_on;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_a_forward_pin = pins_r[0];
  assign out_a_reverse_pin = pins_r[1];
  assign out_b_forward_pin = pins_r[2];
  assign out_b_reverse_pin = pins_r[3];
  assign out_auto_active   = auto_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dmds_checker.sv =====
// Port-level checker for the dual motor direction sequencer, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
`default_nettype none

module dmds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_a_forward_pin,
  input wire logic        out_a_reverse_pin,
  input wire logic        out_b_forward_pin,
  input wire logic        out_b_reverse_pin,
  input wire logic        out_auto_active
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_a_forward_pin) &&
      $stable(out_a_reverse_pin) && $stable(out_b_forward_pin) &&
      $stable(out_b_reverse_pin) && $stable(out_auto_active))
    else $error("result changed while stalled");

  // bridge never shorted
  a_chan_a_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_a_forward_pin && out_a_reverse_pin))
    else $error("channel A both pins high");

  a_chan_b_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_b_forward_pin && out_b_reverse_pin))
    else $error("channel B both pins high");

  // every accepted item gives a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind dual_motor_direction_sequencer_top dmds_checker u_dmds_checker (.*);

`default_nettype wire
